[design/lts_pkg.sv]
// ---------------------------------------------------------------------------
// lts_pkg - shared types and constants of the lexical token scanner
// Token kinds, scanner modes and the token/group records that travel from
// the front end through the queue to the output stage.
// ---------------------------------------------------------------------------
package lts_pkg;

	localparam int MAX_LEXEME_DEF = 256;
	localparam int Q_DEPTH_DEF    = 4;
	localparam logic [15:0] LINE_MAX = 16'hFFFF;

	typedef enum logic [4:0] {
		K_READ    = 5'd0,
		K_PRINT   = 5'd1,
		K_IF      = 5'd2,
		K_ELSE    = 5'd3,
		K_BEGIN   = 5'd4,
		K_END_KW  = 5'd5,
		K_IDENT   = 5'd6,
		K_INT     = 5'd7,
		K_ASSIGN  = 5'd8,
		K_COLON   = 5'd9,
		K_INC     = 5'd10,
		K_ADD     = 5'd11,
		K_DEC     = 5'd12,
		K_SUB     = 5'd13,
		K_POW     = 5'd14,
		K_MUL     = 5'd15,
		K_DIV     = 5'd16,
		K_LE      = 5'd17,
		K_NE      = 5'd18,
		K_LT      = 5'd19,
		K_GE      = 5'd20,
		K_GT      = 5'd21,
		K_EQ      = 5'd22,
		K_LPAR    = 5'd23,
		K_RPAR    = 5'd24,
		K_SEMI    = 5'd25,
		K_UNKNOWN = 5'd26,
		K_EOF     = 5'd27
	} kind_t;

	typedef enum logic [3:0] {
		M_IDLE,
		M_WORD,
		M_NUM,
		M_COLON,
		M_PLUS,
		M_MINUS,
		M_STAR,
		M_LESS,
		M_GREATER
	} mode_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] len;
		logic [7:0] unk;
	} tok_t;

	// One input item's results: one or two tokens, all on the same line.
	typedef struct packed {
		tok_t        tok0;
		tok_t        tok1;
		logic        two;
		logic [15:0] line;
	} grp_t;

	// Queue handshake toward the output stage.
	typedef struct packed {
		logic empty;
		grp_t head;
	} q_rd_t;

endpackage

[design/lts_front.sv]
// ---------------------------------------------------------------------------
// lts_front - byte classifier and scanner state
// Takes one byte per cycle while take is high, tracks the open token and builds
// the group of tokens that the byte closes.
// ---------------------------------------------------------------------------
module lts_front import lts_pkg::*; #(
	parameter int MAX_LEXEME = MAX_LEXEME_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  logic [7:0] char_byte,
	input  logic       end_of_input,
	output logic       grp_vld,
	output grp_t       grp
);

	localparam int LEN_CAP_I = (MAX_LEXEME - 1) < 255 ? (MAX_LEXEME - 1) : 255;
	localparam logic [7:0] LEN_CAP = 8'(LEN_CAP_I);

	function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [2:0] idx);
		logic [7:0] c;
		c = 8'h00;
		unique case (k)
			3'd0: case (idx) 3'd0: c = "r"; 3'd1: c = "e"; 3'd2: c = "a"; 3'd3: c = "d";
				default: c = 8'h00; endcase
			3'd1: case (idx) 3'd0: c = "p"; 3'd1: c = "r"; 3'd2: c = "i"; 3'd3: c = "n";
				3'd4: c = "t"; default: c = 8'h00; endcase
			3'd2: case (idx) 3'd0: c = "i"; 3'd1: c = "f"; default: c = 8'h00; endcase
			3'd3: case (idx) 3'd0: c = "e"; 3'd1: c = "l"; 3'd2: c = "s"; 3'd3: c = "e";
				default: c = 8'h00; endcase
			3'd4: case (idx) 3'd0: c = "b"; 3'd1: c = "e"; 3'd2: c = "g"; 3'd3: c = "i";
				3'd4: c = "n"; default: c = 8'h00; endcase
			3'd5: case (idx) 3'd0: c = "e"; 3'd1: c = "n"; 3'd2: c = "d";
				default: c = 8'h00; endcase
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] kw_len(input logic [2:0] k);
		logic [7:0] n;
		unique case (k)
			3'd0: n = 8'd4;
			3'd1: n = 8'd5;
			3'd2: n = 8'd2;
			3'd3: n = 8'd4;
			3'd4: n = 8'd5;
			3'd5: n = 8'd3;
			default: n = 8'd0;
		endcase
		return n;
	endfunction

	mode_t       mode_q, mode_d;
	logic [5:0]  cand_q, cand_d;
	logic [7:0]  len_q, len_d;
	logic [15:0] line_q, line_d;

	logic is_letter, is_digit, is_space, is_eol;
	logic done, pair_hit;
	kind_t pair_kind;
	logic  c_vld, p_vld, f_vld;
	tok_t  c_tok, p_tok, f_tok;
	logic [5:0] ext_cand, first_cand;

	assign is_letter = (char_byte >= "a" && char_byte <= "z") ||
		(char_byte >= "A" && char_byte <= "Z");
	assign is_digit  = char_byte >= "0" && char_byte <= "9";
	assign is_space  = char_byte == " " || (char_byte >= 8'd9 && char_byte <= 8'd13);
	assign is_eol    = char_byte == 8'd10;

	// keyword candidate tracking
	always_comb begin
		for (int k = 0; k < 6; k++) begin
			ext_cand[k] = cand_q[k] && (len_q < kw_len(3'(k))) &&
				(kw_char(3'(k), len_q[2:0]) == char_byte);
			first_cand[k] = kw_char(3'(k), 3'd0) == char_byte;
		end
	end

	// does the byte continue the open token, and does it finish a pair
	always_comb begin
		done = 1'b0;
		pair_hit = 1'b0;
		pair_kind = K_UNKNOWN;
		unique case (mode_q)
			M_WORD:    done = is_letter || is_digit || char_byte == "_";
			M_NUM:     done = is_digit;
			M_COLON:   begin pair_hit = char_byte == "="; pair_kind = K_ASSIGN; end
			M_PLUS:    begin pair_hit = char_byte == "+"; pair_kind = K_INC; end
			M_MINUS:   begin pair_hit = char_byte == "-"; pair_kind = K_DEC; end
			M_STAR:    begin pair_hit = char_byte == "*"; pair_kind = K_POW; end
			M_LESS: begin
				pair_hit = char_byte == "=" || char_byte == ">";
				pair_kind = (char_byte == "=") ? K_LE : K_NE;
			end
			M_GREATER: begin pair_hit = char_byte == "="; pair_kind = K_GE; end
			default:   done = 1'b0;
		endcase
	end

	// token that closes the open one
	always_comb begin
		c_vld = mode_q != M_IDLE;
		c_tok = '{kind: K_IDENT, len: 8'd1, unk: 8'h00};
		unique case (mode_q)
			M_WORD: begin
				c_tok.len = len_q;
				for (int k = 0; k < 6; k++)
					if (cand_q[k] && len_q == kw_len(3'(k)))
						c_tok.kind = kind_t'(5'(k));
			end
			M_NUM:     begin c_tok.kind = K_INT; c_tok.len = len_q; end
			M_COLON:   c_tok.kind = K_COLON;
			M_PLUS:    c_tok.kind = K_ADD;
			M_MINUS:   c_tok.kind = K_SUB;
			M_STAR:    c_tok.kind = K_MUL;
			M_LESS:    c_tok.kind = K_LT;
			M_GREATER: c_tok.kind = K_GT;
			default:   c_tok.kind = K_IDENT;
		endcase
	end

	// next state
	always_comb begin
		mode_d = mode_q;
		cand_d = cand_q;
		len_d  = len_q;
		line_d = line_q;
		if (end_of_input) begin
			mode_d = M_IDLE;
			cand_d = '0;
			len_d  = '0;
			line_d = 16'd1;
		end else if (done) begin
			if (mode_q == M_WORD)
				cand_d = ext_cand;
			if (len_q < LEN_CAP)
				len_d = len_q + 8'd1;
		end else if (pair_hit) begin
			mode_d = M_IDLE;
		end else begin
			mode_d = M_IDLE;
			cand_d = '0;
			len_d  = '0;
			if (is_space) begin
				if (is_eol && line_q != LINE_MAX)
					line_d = line_q + 16'd1;
			end else if (is_letter) begin
				mode_d = M_WORD;
				len_d  = 8'd1;
				cand_d = first_cand;
			end else if (is_digit) begin
				mode_d = M_NUM;
				len_d  = 8'd1;
			end else begin
				case (char_byte)
					":": mode_d = M_COLON;
					"+": mode_d = M_PLUS;
					"-": mode_d = M_MINUS;
					"*": mode_d = M_STAR;
					"<": mode_d = M_LESS;
					">": mode_d = M_GREATER;
					default: mode_d = M_IDLE;
				endcase
			end
		end
	end

	// emitted tokens: p = closed token, f = token of this byte
	always_comb begin
		p_vld = 1'b0;
		p_tok = c_tok;
		f_vld = 1'b0;
		f_tok = '{kind: K_EOF, len: 8'd0, unk: 8'h00};
		if (end_of_input) begin
			p_vld = c_vld;
			f_vld = 1'b1;
		end else if (done) begin
			f_vld = 1'b0;
		end else if (pair_hit) begin
			f_vld = 1'b1;
			f_tok = '{kind: pair_kind, len: 8'd2, unk: 8'h00};
		end else begin
			p_vld = c_vld;
			f_tok.len = 8'd1;
			if (!is_space && !is_letter && !is_digit) begin
				f_vld = 1'b1;
				case (char_byte) inside
					":", "+", "-", "*", "<", ">": f_vld = 1'b0;
					"/": f_tok.kind = K_DIV;
					"=": f_tok.kind = K_EQ;
					"(": f_tok.kind = K_LPAR;
					")": f_tok.kind = K_RPAR;
					";": f_tok.kind = K_SEMI;
					default: begin
						f_tok.kind = K_UNKNOWN;
						f_tok.unk  = char_byte;
					end
				endcase
			end
		end
	end

	assign grp_vld   = take && (p_vld || f_vld);
	assign grp.tok0  = p_vld ? p_tok : f_tok;
	assign grp.tok1  = f_tok;
	assign grp.two   = p_vld && f_vld;
	assign grp.line  = line_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			cand_q <= '0;
			len_q  <= '0;
			line_q <= 16'd1;
		end else if (take) begin
			mode_q <= mode_d;
			cand_q <= cand_d;
			len_q  <= len_d;
			line_q <= line_d;
		end
	end

endmodule

[design/lts_queue.sv]
// ---------------------------------------------------------------------------
// lts_queue - token group queue
// Short register queue that decouples the scanner from the output stage.
// ---------------------------------------------------------------------------
module lts_queue import lts_pkg::*; #(
	parameter int DEPTH = Q_DEPTH_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  wr_en,
	input  grp_t  wr_data,
	output logic  full,
	input  logic  rd_en,
	output q_rd_t rd
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

	grp_t          mem_q [DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;

	assign full     = cnt_q == CNT_FULL;
	assign rd.empty = cnt_q == '0;
	assign rd.head  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en)
				wp_q <= (wp_q == PTR_LAST) ? '0 : wp_q + PW'(1);
			if (rd_en)
				rp_q <= (rp_q == PTR_LAST) ? '0 : rp_q + PW'(1);
			if (wr_en && !rd_en)
				cnt_q <= cnt_q + CW'(1);
			else if (rd_en && !wr_en)
				cnt_q <= cnt_q - CW'(1);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> !full || rd_en)
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> !rd.empty)
		else $error("queue read while empty");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		##1 cnt_q == $past(cnt_q) + CW'($past(wr_en)) - CW'($past(rd_en)))
		else $error("queue count out of step");

endmodule

[design/lts_back.sv]
// ---------------------------------------------------------------------------
// lts_back - output stage
// Splits each queued group into single tokens and holds them in the output
// register until taken.
// ---------------------------------------------------------------------------
module lts_back import lts_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  q_rd_t       rd,
	output logic        rd_en,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [4:0]  token_kind,
	output logic [7:0]  lexeme_length,
	output logic [15:0] line_number,
	output logic [7:0]  unknown_byte,
	output logic        last
);

	logic        vld_q, half_q, load;
	tok_t        tok_q, nxt_tok;
	logic [15:0] line_q;
	logic        last_q, nxt_last;

	assign load = (!vld_q || out_ready) && !rd.empty;

	// a single-token group, or the second half of a two-token group, pops the entry
	always_comb begin
		if (rd.head.two && !half_q) begin
			nxt_tok  = rd.head.tok0;
			nxt_last = 1'b0;
		end else if (rd.head.two) begin
			nxt_tok  = rd.head.tok1;
			nxt_last = 1'b1;
		end else begin
			nxt_tok  = rd.head.tok0;
			nxt_last = 1'b1;
		end
	end

	assign rd_en = load && nxt_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= 1'b0;
			half_q <= 1'b0;
		end else begin
			if (load) begin
				vld_q  <= 1'b1;
				half_q <= !nxt_last;
			end else if (out_ready) begin
				vld_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			tok_q  <= nxt_tok;
			line_q <= rd.head.line;
			last_q <= nxt_last;
		end
	end

	assign out_valid     = vld_q;
	assign token_kind    = tok_q.kind;
	assign lexeme_length = tok_q.len;
	assign line_number   = line_q;
	assign unknown_byte  = tok_q.unk;
	assign last          = last_q;

endmodule

[design/lexical_token_scanner.sv]
// ---------------------------------------------------------------------------
// lexical_token_scanner - byte stream to token stream
// Scans one source byte per item and delivers keyword, identifier, integer,
// operator, unknown and end tokens with their length and line number.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one item per byte; char_byte is the
//   source byte, end_of_input closes the source. An end item flushes any
//   open token, then gives the end token, and the scanner returns to line 1.
//   Output channel (out_valid/out_ready): one item per token; last marks the
//   final token caused by one input item (an item gives zero, one or two).
// Throughput: one input item per cycle while the queue is not full. The output
//   register delivers one token per cycle while out_ready is high, so items that
//   close two tokens need two output transfers; the group queue (Q_DEPTH entries)
//   absorbs those bursts. A token caused by an accepted item is written into the
//   queue, then loaded into the output register that drives the output ports.
// Stalls: while out_ready is low the output register holds its token, the
//   queue fills, and in_ready drops only once the queue is full.
// Reset: arst_n clears scanner mode, length and keyword state, sets the line
//   count to 1 and empties the queue and the output register.
// ---------------------------------------------------------------------------
module lexical_token_scanner import lts_pkg::*; #(
	parameter int MAX_LEXEME = MAX_LEXEME_DEF,
	parameter int Q_DEPTH    = Q_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  char_byte,
	input  logic        end_of_input,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [4:0]  token_kind,
	output logic [7:0]  lexeme_length,
	output logic [15:0] line_number,
	output logic [7:0]  unknown_byte,
	output logic        last
);

	logic  take, q_full, grp_vld, rd_en;
	grp_t  grp;
	q_rd_t q_rd;

	// a byte is taken whenever it is valid and the queue is not full
	assign in_ready = !q_full;
	assign take     = in_valid && in_ready;

	lts_front #(
		.MAX_LEXEME(MAX_LEXEME)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.take         (take),
		.char_byte    (char_byte),
		.end_of_input (end_of_input),
		.grp_vld      (grp_vld),
		.grp          (grp)
	);

	lts_queue #(
		.DEPTH(Q_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (grp_vld),
		.wr_data (grp),
		.full    (q_full),
		.rd_en   (rd_en),
		.rd      (q_rd)
	);

	lts_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.rd            (q_rd),
		.rd_en         (rd_en),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.token_kind    (token_kind),
		.lexeme_length (lexeme_length),
		.line_number   (line_number),
		.unknown_byte  (unknown_byte),
		.last          (last)
	);

endmodule
